>>> src/lpmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmd_pkg
// Shared types and constants for the length-prefixed message deframer.
// ----------------------------------------------------------------------------
package lpmd_pkg;

    localparam int unsigned LEN_W        = 32;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned KIND_W       = 2;
    localparam int unsigned HDR_CNT_W    = 2;
    localparam int unsigned OUT_TDATA_W  = 40;

    // Length prefix reset value of the maximum length register
    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 32'd1048576;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_KEEPALIVE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ID        = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OVERSIZE  = 2'd3;

    // One result item
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] value;
        logic [LEN_W-1:0]  payload_length;
        logic              last;
    } result_t;

endpackage

>>> src/length_prefixed_message_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer
// Splits a byte stream into keep-alive, id, payload and oversize results
// using a 4-byte big-endian length prefix.
// ----------------------------------------------------------------------------
//  channel | direction | payload                                | transaction
//  s_*     | in        | tdata[7:0] data_byte                   | tvalid & tready
//  m_*     | out       | tdata value, payload_length; tuser kind | tvalid & tready
//          |           | tlast last                             |
//  cfg_*   | in        | cfg_data max_length                    | cfg_valid & cfg_ready
//
//  One byte is accepted per cycle while s_tready is high; its result, if any, is
//  registered in the result register, or in a one-entry skid register if that is
//  full and stalled. The two decouple the sides, so s_tready drops only when both
//  are full under a stalled m_tready. Reset clears framing state and sets max_length
//  to 1048576; a length above it leaves the block discarding bytes until reset.
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer
    import lpmd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] value, [39:8] payload_length
    output logic [KIND_W-1:0]      m_tuser,   // [1:0] kind
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [LEN_W-1:0]       cfg_data
);

    logic [LEN_W-1:0] max_len_reg;
    logic             in_fire;
    logic             out_pop;
    logic             res_valid;
    result_t          res;
    logic             out_valid_reg;
    result_t          out_reg;
    logic             skid_valid_reg;
    result_t          skid_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign in_fire   = s_tvalid && s_tready;
    assign out_pop   = out_valid_reg && m_tready;

    // Hold the maximum length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LENGTH_RESET;
        end
        else if (cfg_valid)
        begin
            max_len_reg <= cfg_data;
        end
    end

    lpmd_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .data_byte  (s_tdata),
        .max_length (max_len_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Advance results through the output and skid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || out_pop)
        begin
            out_valid_reg <= res_valid;
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Move result payloads
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (!out_valid_reg || out_pop)
        begin
            out_reg <= res;
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.payload_length, out_reg.value};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

endmodule

>>> src/lpmd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmd_core
// Framing state machine: gathers the length prefix (keep-alive or oversize), then
// classifies each byte as id, payload or discarded, one byte per cycle on in_fire.
// ----------------------------------------------------------------------------
module lpmd_core
    import lpmd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [LEN_W-1:0]  max_length,
    output logic              res_valid,
    output result_t           res
);

    localparam logic [1:0] PHASE_HEADER  = 2'd0;
    localparam logic [1:0] PHASE_ID      = 2'd1;
    localparam logic [1:0] PHASE_PAYLOAD = 2'd2;
    localparam logic [1:0] PHASE_ERROR   = 2'd3;

    logic [1:0]           phase_reg, phase_next;
    logic [HDR_CNT_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [LEN_W-1:0]     len_acc_reg, len_acc_next;
    logic [LEN_W-1:0]     remain_reg, remain_next;
    logic [LEN_W-1:0]     len_full;
    logic [LEN_W-1:0]     remain_dec;

    assign len_full   = {len_acc_reg[LEN_W-BYTE_W-1:0], data_byte};
    assign remain_dec = (remain_reg != '0) ? (remain_reg - 1'b1) : remain_reg;

    // Decode the current byte and advance the framing state
    always_comb
    begin
        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        len_acc_next = len_acc_reg;
        remain_next  = remain_reg;
        res_valid    = 1'b0;
        res          = '{kind: KIND_KEEPALIVE, value: '0, payload_length: '0, last: 1'b1};

        if (in_fire)
        begin
            case (phase_reg)
                PHASE_HEADER:
                begin
                    hdr_cnt_next = hdr_cnt_reg + 1'b1;
                    len_acc_next = len_full;
                    if (hdr_cnt_reg == '1)
                    begin
                        len_acc_next = '0;
                        if (len_full == '0)
                        begin
                            res_valid = 1'b1;
                        end
                        else if (len_full > max_length)
                        begin
                            res_valid   = 1'b1;
                            res.kind    = KIND_OVERSIZE;
                            phase_next  = PHASE_ERROR;
                        end
                        else
                        begin
                            remain_next = len_full - 1'b1;
                            phase_next  = PHASE_ID;
                        end
                    end
                end
                PHASE_ID:
                begin
                    res_valid          = 1'b1;
                    res.kind           = KIND_ID;
                    res.value          = data_byte;
                    res.payload_length = remain_reg;
                    res.last           = (remain_reg == '0);
                    phase_next         = (remain_reg == '0) ? PHASE_HEADER : PHASE_PAYLOAD;
                end
                PHASE_PAYLOAD:
                begin
                    remain_next = remain_dec;
                    res_valid   = 1'b1;
                    res.kind    = KIND_PAYLOAD;
                    res.value   = data_byte;
                    res.last    = (remain_dec == '0);
                    if (remain_dec == '0)
                    begin
                        phase_next = PHASE_HEADER;
                    end
                end
                default:
                begin
                    // Drop every byte until reset
                    phase_next = PHASE_ERROR;
                end
            endcase
        end
    end

    // Hold framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PHASE_HEADER;
            hdr_cnt_reg <= '0;
            len_acc_reg <= '0;
            remain_reg  <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            len_acc_reg <= len_acc_next;
            remain_reg  <= remain_next;
        end
    end

endmodule

>>> tb/length_prefixed_message_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer_tb
// Drives framed byte traffic into the deframer under random stalls on both
// sides and checks every result against a cycle-free model of the framing
// rules: length prefix, keep-alive, id, payload and the oversize lockout.
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer_tb;
    import lpmd_pkg::*;

    localparam int PREFIX_BYTES     = 4;
    localparam int RESET_CYCLES     = 7;
    localparam int SETTLE_CYCLES    = 4;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int TARGET_ITEMS     = 1650;
    localparam int MAX_PRINTED      = 100;

    typedef enum logic [1:0] {PH_HEADER, PH_ID, PH_PAYLOAD, PH_ERROR} frame_phase_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata   = '0;   // [7:0] data_byte
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // [7:0] value, [39:8] payload_length
    logic [KIND_W-1:0]      m_tuser;          // [1:0] kind
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [LEN_W-1:0]       cfg_data  = '0;

    // Framing state mirrored by the predictor
    frame_phase_t     frm_phase = PH_HEADER;
    int               hdr_count = 0;
    logic [LEN_W-1:0] len_acc   = '0;
    logic [LEN_W-1:0] remaining = '0;
    logic [LEN_W-1:0] max_len   = MAX_LENGTH_RESET;

    result_t deframed_results[$];
    int      mismatch_count = 0;
    int      bytes_sent     = 0;
    int      idle_cycles    = 0;
    bit      quiet          = 1'b0;
    int      long_hold      = 0;

    length_prefixed_message_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Mostly no gap, some short ones, a few long ones, none during quiet stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [LEN_W-1:0] pick_length(input logic [LEN_W-1:0] cap);
        logic [LEN_W-1:0] len;
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            len = 0;
        else if (r < 30)
            len = 1;
        else if (r < 75)
            len = $urandom_range(2, 8);
        else if (r < 95)
            len = $urandom_range(9, 40);
        else
            len = $urandom_range(41, 150);
        return (len > cap) ? cap : len;
    endfunction

    function automatic logic [LEN_W-1:0] pick_max_length();
        case ($urandom_range(0, 5))
            0: return 32'd1;
            1: return 32'd2;
            2: return 32'hFFFF_FFFF;
            3: return MAX_LENGTH_RESET;
            4: return $urandom_range(3, 40);
            default: return $urandom_range(32'hFFFF_FFFF, 41);
        endcase
    endfunction

    function automatic void queue_result(input logic [KIND_W-1:0] kind,
                                         input logic [BYTE_W-1:0] value,
                                         input logic [LEN_W-1:0] plen,
                                         input logic last);
        result_t r;
        r.kind           = kind;
        r.value          = value;
        r.payload_length = plen;
        r.last           = last;
        deframed_results.push_back(r);
    endfunction

    // Advance the framing state by one accepted byte
    function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
        case (frm_phase)
            PH_HEADER:
            begin
                len_acc   = {len_acc[LEN_W-9:0], b};
                hdr_count = hdr_count + 1;
                if (hdr_count == PREFIX_BYTES)
                begin
                    hdr_count = 0;
                    if (len_acc == 0)
                        queue_result(KIND_KEEPALIVE, '0, '0, 1'b1);
                    else if (len_acc > max_len)
                    begin
                        frm_phase = PH_ERROR;
                        len_acc   = '0;
                        queue_result(KIND_OVERSIZE, '0, '0, 1'b1);
                    end
                    else
                    begin
                        remaining = len_acc - 1;
                        len_acc   = '0;
                        frm_phase = PH_ID;
                    end
                end
            end
            PH_ID:
            begin
                queue_result(KIND_ID, b, remaining, remaining == 0);
                frm_phase = (remaining == 0) ? PH_HEADER : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                if (remaining != 0)
                    remaining = remaining - 1;
                queue_result(KIND_PAYLOAD, b, '0, remaining == 0);
                if (remaining == 0)
                    frm_phase = PH_HEADER;
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [LEN_W-1:0] got,
                                   input logic [LEN_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch on %s at %0t: got 0x%0h, wanted 0x%0h",
                     field, $time, got, want);
    endtask

    // Offer one byte after a random gap; hold tvalid until the transaction
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
        deframe_byte(b);
    endtask

    // Stop offering, drain all results, then let the pipeline settle
    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        while (deframed_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_max_length(input logic [LEN_W-1:0] value);
        wait_for_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        max_len = value;
    endtask

    // Send prefix plus random body; reconfigure just before byte split_at
    task automatic send_message(input logic [LEN_W-1:0] len, input int split_at,
                                input logic [LEN_W-1:0] new_max);
        logic [BYTE_W-1:0] frame[$];
        frame = {len[31:24], len[23:16], len[15:8], len[7:0]};
        repeat (len) frame.push_back(BYTE_W'($urandom));
        foreach (frame[i])
        begin
            if (i == split_at)
                set_max_length(new_max);
            send_byte(frame[i]);
        end
    endtask

    task automatic send_frame(input logic [LEN_W-1:0] len);
        send_message(len, -1, '0);
    endtask

    // Keep-alive, single-byte messages and id/payload byte extremes
    task automatic test_directed_frames();
        logic [BYTE_W-1:0] bytes[$];
        bytes = {8'h00, 8'h00, 8'h00, 8'h00,
                 8'h00, 8'h00, 8'h00, 8'h01, 8'h00,
                 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF,
                 8'h00, 8'h00, 8'h00, 8'h03, 8'hFF, 8'h00, 8'hFF};
        foreach (bytes[i])
            send_byte(bytes[i]);
    endtask

    // Lengths at and below the configured limit
    task automatic test_max_length_limits();
        set_max_length(32'd1);
        send_frame(1);
        send_frame(0);
        send_frame(1);
        set_max_length(32'd5);
        send_frame(5);
        set_max_length(32'hFFFF_FFFF);
        send_frame(300);
    endtask

    // New limit applies only at the next completed prefix
    task automatic test_config_mid_message();
        set_max_length(32'd64);
        send_message(20, 9, 32'd2);
        send_frame(2);
        send_frame(1);
        send_message(8, 2, 32'd8);
        set_max_length(32'hFFFF_FFFF);
    endtask

    // Hold off the receiver while the sender streams, then pause the sender
    task automatic test_output_stall();
        quiet     = 1'b1;
        long_hold = LONG_HOLD_CYCLES;
        send_frame(48);
        quiet = 1'b0;
        wait_for_idle();
    endtask

    task automatic test_random_traffic();
        logic [LEN_W-1:0] next_max;
        logic [LEN_W-1:0] cap;
        logic [LEN_W-1:0] len;
        while (bytes_sent < TARGET_ITEMS)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(10, 30))
                send_frame(pick_length(max_len));
            // reconfigure somewhere inside a message
            next_max = pick_max_length();
            cap      = (next_max < max_len) ? next_max : max_len;
            len      = pick_length(cap);
            send_message(len, $urandom_range(0, PREFIX_BYTES + len - 1), next_max);
        end
        quiet = 1'b0;
    endtask

    // Length one above the limit locks the framer; later bytes are dropped
    task automatic test_oversize_lockout();
        set_max_length(32'hFFFF_FFFE);
        send_frame(3);
        repeat (PREFIX_BYTES) send_byte(8'hFF);
        repeat (40) send_byte(BYTE_W'($urandom));
    endtask

    // Receiver: random stalls, plus a long hold on request
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold != 0)
            begin
                stall_left = long_hold;
                long_hold  = 0;
            end
            else if (stall_left == 0 && !quiet && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (deframed_results.size() == 0)
                report_mismatch("unpredicted result kind", LEN_W'(m_tuser), '0);
            else
            begin
                want = deframed_results.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("kind", LEN_W'(m_tuser), LEN_W'(want.kind));
                if (m_tdata[7:0] !== want.value)
                    report_mismatch("value", LEN_W'(m_tdata[7:0]), LEN_W'(want.value));
                if (m_tdata[39:8] !== want.payload_length)
                    report_mismatch("payload_length", m_tdata[39:8], want.payload_length);
                if (m_tlast !== want.last)
                    report_mismatch("last", LEN_W'(m_tlast), LEN_W'(want.last));
            end
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("length_prefixed_message_deframer_tb: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_frames();
        test_max_length_limits();
        test_config_mid_message();
        test_output_stall();
        test_random_traffic();
        test_oversize_lockout();
        wait_for_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && deframed_results.size() == 0)
            $display("length_prefixed_message_deframer_tb: PASS");
        else
            $display("length_prefixed_message_deframer_tb: FAIL");
        $finish;
    end

endmodule
